// File: rtl/core/trsq_pkg.sv
package trsq_pkg;

  // field widths
  localparam int SampleW  = 16;
  localparam int ShareW   = 17;
  localparam int QbitsW   = 4;
  localparam int TokenW   = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;

  // token bits below the sign: the largest scale is 2^15 - 1
  localparam int QuotW = 15;

  // unity in the q1.16 share format
  localparam logic [ShareW-1:0] ShareOne = 17'd65536;

  localparam logic signed [TokenW-1:0] InvalidToken = 16'sh8000;

  // register reset values
  localparam logic signed [SampleW-1:0] FineLowRst   = -16'sd4096;
  localparam logic signed [SampleW-1:0] FineHighRst  = 16'sd4096;
  localparam logic [ShareW-1:0]         FineShareRst = 17'd32768;
  localparam logic [QbitsW-1:0]         QuantBitsRst = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FINE_LOW   = 2'd0,
    CFG_FINE_HIGH  = 2'd1,
    CFG_FINE_SHARE = 2'd2,
    CFG_QUANT_BITS = 2'd3
  } cfg_idx_e;

  // control that travels beside the data of each beat
  typedef struct packed {
    logic valid;
    logic invalid;
  } beat_ctl_t;

endpackage

// File: rtl/core/trsq_div.sv
module trsq_div #(
  parameter int DenW = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  trsq_pkg::beat_ctl_t                 ctl_i,
  input  logic [DenW+trsq_pkg::QuotW-1:0]     num_i,
  input  logic [DenW-1:0]                     den_i,
  output trsq_pkg::beat_ctl_t                 ctl_o,
  output logic [trsq_pkg::QuotW-1:0]          quot_o
);

  localparam int QW = trsq_pkg::QuotW;

  // one restoring step per stage, quotient msb first
  trsq_pkg::beat_ctl_t ctl_q [QW];
  logic [DenW-1:0]     rem_q [QW];
  logic [QW-1:0]       low_q [QW];
  logic [DenW-1:0]     den_q [QW];
  logic [QW-1:0]       quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    trsq_pkg::beat_ctl_t ctl_p;
    logic [DenW-1:0]     rem_p;
    logic [QW-1:0]       low_p;
    logic [DenW-1:0]     den_p;
    logic [QW-1:0]       quo_p;
    logic [DenW:0]       trial;
    logic [DenW+1:0]     diff;
    logic                take;

    if (k == 0) begin : g_first
      // upper part of the numerator is already below the divisor
      assign ctl_p = ctl_i;
      assign rem_p = num_i[DenW+QW-1:QW];
      assign low_p = num_i[QW-1:0];
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_next
      assign ctl_p = ctl_q[k-1];
      assign rem_p = rem_q[k-1];
      assign low_p = low_q[k-1];
      assign den_p = den_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    always_comb begin
      trial = {rem_p, low_p[QW-1]};
      diff  = {1'b0, trial} - {2'b00, den_p};
      take  = ~diff[DenW+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? diff[DenW-1:0] : trial[DenW-1:0];
      low_q[k] <= {low_p[QW-2:0], 1'b0};
      den_q[k] <= den_p;
      quo_q[k] <= {quo_p[QW-2:0], take};
    end
  end

  assign ctl_o  = ctl_q[QW-1];
  assign quot_o = quo_q[QW-1];

endmodule

// File: rtl/core/two_region_sample_quantizer_top.sv
// channel  | direction | handshake                     | payload
// ---------+-----------+-------------------------------+-------------------------------
// sample   | in        | start & !busy                 | sample_i, is_invalid_i
// token    | out       | done_o, one cycle, no backoff | token_o
// config   | in        | cfg_valid_i & cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one sample beat per cycle; busy never rises
// from accept to the done_o cycle a beat passes through the four front stages,
//   the 15-stage restoring divider and the output register
// rst_ni clears the valid bits of every stage and loads the register defaults
// the token side has no stall, so the pipeline always advances
// cfg_ready_o is always high; write only while no beat is in flight
module two_region_sample_quantizer_top #(
  parameter int SAMPLE_FRAC_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // sample beats
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [trsq_pkg::SampleW-1:0]    sample_i,
  input  logic                                   is_invalid_i,
  // token beats
  output logic                                   done_o,
  output logic signed [trsq_pkg::TokenW-1:0]     token_o,
  // register writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [trsq_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [trsq_pkg::CfgDataW-1:0]          cfg_data_i
);

  // clamp limit and full span of the clamped range, in sample lsbs
  localparam int Lim     = 3 << SAMPLE_FRAC_BITS;
  localparam int Span    = 6 << SAMPLE_FRAC_BITS;
  localparam int SpanW   = $clog2(Span + 1);
  // divisor: fine window gives span<<16, coarse maps give Span<<17
  localparam int DenW    = (SpanW + 17 > 32) ? SpanW + 17 : 32;
  localparam int OpbRawW = $clog2(2 * Span + 1);
  localparam int OpbW    = (OpbRawW > 16) ? OpbRawW : 16;
  localparam int OpaW    = trsq_pkg::ShareW;
  localparam int NumW    = DenW + 1;
  localparam int QW      = trsq_pkg::QuotW;
  localparam int XW      = DenW + QW;
  localparam int Latency = 5 + QW;

  localparam logic signed [17:0] LimS      = 18'(Lim);
  localparam logic [OpbW-1:0]    SpanB     = OpbW'(Span);
  localparam logic [NumW-1:0]    TwoSpan   = NumW'(2 * Span);
  localparam logic [DenW-1:0]    CoarseDen = DenW'(Span) << 17;

  logic accept;
  assign accept      = start & ~busy;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [trsq_pkg::SampleW-1:0] fine_low_q, fine_high_q;
  logic [trsq_pkg::ShareW-1:0]         fine_share_q;
  logic [trsq_pkg::QbitsW-1:0]         quant_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_low_q   <= trsq_pkg::FineLowRst;
      fine_high_q  <= trsq_pkg::FineHighRst;
      fine_share_q <= trsq_pkg::FineShareRst;
      quant_bits_q <= trsq_pkg::QuantBitsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (trsq_pkg::cfg_idx_e'(cfg_index_i))
        trsq_pkg::CFG_FINE_LOW:   fine_low_q   <= cfg_data_i[15:0];
        trsq_pkg::CFG_FINE_HIGH:  fine_high_q  <= cfg_data_i[15:0];
        trsq_pkg::CFG_FINE_SHARE: fine_share_q <= cfg_data_i;
        trsq_pkg::CFG_QUANT_BITS: quant_bits_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: clamp the sample to +-3.0
  // ---------------------------------------------------------------------------
  trsq_pkg::beat_ctl_t c1_d, c1_q;
  logic signed [17:0]  sample_x, clamp_x;
  logic signed [15:0]  s1_q;

  always_comb begin
    c1_d     = '{valid: accept, invalid: is_invalid_i};
    sample_x = {{2{sample_i[15]}}, sample_i};
    if (sample_x < -LimS) begin
      clamp_x = -LimS;
    end else if (sample_x > LimS) begin
      clamp_x = LimS;
    end else begin
      clamp_x = sample_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
    end else begin
      c1_q <= c1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= clamp_x[15:0];
  end

  // ---------------------------------------------------------------------------
  // stage 2: window test, multiplier operands and divisor
  // fine:   num = r * (s - low),                den = (high - low) << 16, or 1 if high == low
  // coarse: num = 2*r*span + (1-r)*(u [+ span]), den = span << 17
  // ---------------------------------------------------------------------------
  trsq_pkg::beat_ctl_t c2_q;
  logic signed [16:0]  s_ext, fl_ext, fh_ext, diff_lo, win_span;
  logic signed [17:0]  u_s;
  logic                in_win, degen;
  logic [OpaW-1:0]     r_w, opa_d, opa_q;
  logic [OpbW-1:0]     opb_d, opb_q;
  logic [NumW-1:0]     addc_d, addc_q;
  logic [DenW-1:0]     den_d, den2_q;
  logic                zero_d, zero2_q;

  always_comb begin
    s_ext    = {s1_q[15], s1_q};
    fl_ext   = {fine_low_q[15], fine_low_q};
    fh_ext   = {fine_high_q[15], fine_high_q};
    in_win   = (s_ext >= fl_ext) && (s_ext <= fh_ext);
    degen    = (fine_high_q == fine_low_q);
    diff_lo  = s_ext - fl_ext;
    win_span = fh_ext - fl_ext;
    u_s      = {{2{s1_q[15]}}, s1_q} + LimS;
    r_w      = (fine_share_q > trsq_pkg::ShareOne) ? trsq_pkg::ShareOne : fine_share_q;
    zero_d   = in_win && degen;
    if (in_win) begin
      opa_d  = r_w;
      opb_d  = OpbW'(diff_lo[15:0]);
      addc_d = '0;
      den_d  = degen ? DenW'(1) : DenW'({win_span[15:0], 16'h0000});
    end else begin
      opa_d  = trsq_pkg::ShareOne - r_w;
      // upper coarse map adds one more span
      opb_d  = OpbW'($unsigned(u_s)) + (s1_q[15] ? '0 : SpanB);
      addc_d = NumW'(r_w) * TwoSpan;
      den_d  = CoarseDen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q <= '0;
    end else begin
      c2_q <= c1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q   <= opa_d;
    opb_q   <= opb_d;
    addc_q  <= addc_d;
    den2_q  <= den_d;
    zero2_q <= zero_d;
  end

  // ---------------------------------------------------------------------------
  // stage 3: numerator
  // ---------------------------------------------------------------------------
  trsq_pkg::beat_ctl_t   c3_q;
  logic [OpaW+OpbW-1:0]  prod_ab;
  logic [NumW-1:0]       num_q;
  logic [DenW-1:0]       den3_q;
  logic                  zero3_q;

  assign prod_ab = opa_q * opb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
    end else begin
      c3_q <= c2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= NumW'(prod_ab) + addc_q;
    den3_q  <= den2_q;
    zero3_q <= zero2_q;
  end

  // ---------------------------------------------------------------------------
  // stage 4: times 2^quant_bits - 1; the quotient never exceeds that scale
  // ---------------------------------------------------------------------------
  trsq_pkg::beat_ctl_t c4_q;
  logic [15:0]         pow_w;
  logic [QW-1:0]       scale_w;
  logic [NumW+QW-1:0]  prod_x;
  logic [XW-1:0]       x_q;
  logic [DenW-1:0]     den4_q;

  always_comb begin
    pow_w   = 16'(1) << quant_bits_q;
    scale_w = QW'(pow_w - 16'd1);
    prod_x  = num_q * scale_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c4_q <= '0;
    end else begin
      c4_q <= c3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= zero3_q ? '0 : XW'(prod_x);
    den4_q <= den3_q;
  end

  // ---------------------------------------------------------------------------
  // stages 5..19: pipelined divider
  // ---------------------------------------------------------------------------
  trsq_pkg::beat_ctl_t div_ctl;
  logic [QW-1:0]       quot_w;

  trsq_div #(
    .DenW (DenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (c4_q),
    .num_i  (x_q),
    .den_i  (den4_q),
    .ctl_o  (div_ctl),
    .quot_o (quot_w)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic                                done_q;
  logic signed [trsq_pkg::TokenW-1:0]  token_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    token_q <= div_ctl.invalid ? trsq_pkg::InvalidToken : signed'({1'b0, quot_w});
  end

  assign done_o  = done_q;
  assign token_o = token_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("token beat missing after fixed latency");

  a_invalid_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_invalid_i) |-> ##Latency (token_o == trsq_pkg::InvalidToken))
    else $error("invalid sample did not give the invalid token");

  a_valid_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_invalid_i) |-> ##Latency !token_o[trsq_pkg::TokenW-1])
    else $error("valid sample gave a negative token");

endmodule
